[rtl/sgpg_pkg.sv]
// ----------------------------------------------------------------------------
// sgpg_pkg
// Shared constants, register indexes, series tables and pipeline types of the
// spherical grid point generator.
// ----------------------------------------------------------------------------
package sgpg_pkg;

  localparam int unsigned MAX_BANDWIDTH_DEF = 128;

  localparam logic [7:0]  BANDWIDTH_RESET = 8'd32;
  localparam logic [15:0] RADIUS_RESET    = 16'd6400;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_BANDWIDTH = 8'd0;
  localparam logic [7:0] CFG_IDX_RADIUS    = 8'd1;

  // Pi in Q2.30, one in Q2.30 and the rounding half for a shift by 30.
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [46:0] HALF_Q30 = 47'h2000_0000;

  // Taylor series: term k is divided by a constant, done as a multiply by
  // ceil(2^SH / DIV) and a right shift by SH, exact for operands below 2^30.
  localparam int SIN_TERMS = 5;
  localparam int COS_TERMS = 6;

  localparam longint unsigned SIN_DIV [1:5] = '{6, 20, 42, 72, 110};
  localparam int              SIN_SH  [1:5] = '{33, 35, 36, 37, 37};
  localparam longint unsigned COS_DIV [1:6] = '{2, 12, 30, 56, 90, 132};
  localparam int              COS_SH  [1:6] = '{31, 34, 35, 36, 37, 38};

  localparam logic [30:0] SIN_RCP [1:5] = '{
    31'(((64'd1 << SIN_SH[1]) + SIN_DIV[1] - 64'd1) / SIN_DIV[1]),
    31'(((64'd1 << SIN_SH[2]) + SIN_DIV[2] - 64'd1) / SIN_DIV[2]),
    31'(((64'd1 << SIN_SH[3]) + SIN_DIV[3] - 64'd1) / SIN_DIV[3]),
    31'(((64'd1 << SIN_SH[4]) + SIN_DIV[4] - 64'd1) / SIN_DIV[4]),
    31'(((64'd1 << SIN_SH[5]) + SIN_DIV[5] - 64'd1) / SIN_DIV[5])
  };

  localparam logic [30:0] COS_RCP [1:6] = '{
    31'(((64'd1 << COS_SH[1]) + COS_DIV[1] - 64'd1) / COS_DIV[1]),
    31'(((64'd1 << COS_SH[2]) + COS_DIV[2] - 64'd1) / COS_DIV[2]),
    31'(((64'd1 << COS_SH[3]) + COS_DIV[3] - 64'd1) / COS_DIV[3]),
    31'(((64'd1 << COS_SH[4]) + COS_DIV[4] - 64'd1) / COS_DIV[4]),
    31'(((64'd1 << COS_SH[5]) + COS_DIV[5] - 64'd1) / COS_DIV[5]),
    31'(((64'd1 << COS_SH[6]) + COS_DIV[6] - 64'd1) / COS_DIV[6])
  };

  typedef struct packed {
    logic valid;
    logic oor;
  } pipe_ctl_t;

  // Per-angle series state; index 0 is the polar angle, index 1 the azimuth.
  typedef struct packed {
    logic [1:0]         quad;
    logic               swap;
    logic [29:0]        x2;
    logic [29:0]        term_s;
    logic signed [32:0] sum_s;
    logic [30:0]        term_c;
    logic signed [32:0] sum_c;
    logic [29:0]        p_s;
    logic [29:0]        p_c;
  } angle_t;

  typedef angle_t [1:0] angle_pair_t;

endpackage

[rtl/sgpg_in_if.sv]
// ----------------------------------------------------------------------------
// sgpg_in_if
// Input channel: one grid index pair per transaction.
// ----------------------------------------------------------------------------
interface sgpg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_index;
  logic [7:0] column_index;

  modport source (output valid, output ring_index, output column_index, input ready);
  modport sink   (input valid, input ring_index, input column_index, output ready);
endinterface

[rtl/sgpg_out_if.sv]
// ----------------------------------------------------------------------------
// sgpg_out_if
// Result channel: one Cartesian grid point per transaction.
// ----------------------------------------------------------------------------
interface sgpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] point_x;
  logic signed [16:0] point_y;
  logic signed [16:0] point_z;
  logic               index_out_of_range;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output index_out_of_range, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input index_out_of_range, output ready);
endinterface

[rtl/sgpg_cfg_if.sv]
// ----------------------------------------------------------------------------
// sgpg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sgpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sgpg_div_cell.sv]
// ----------------------------------------------------------------------------
// sgpg_div_cell
// One restoring division step for both angles: one quotient bit per cell.
// ----------------------------------------------------------------------------
module sgpg_div_cell #(
  parameter int B_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [B_W-1:0]        divisor,
  input  sgpg_pkg::pipe_ctl_t   ctl_i,
  input  logic [1:0][B_W-1:0]   rem_i,
  input  logic [1:0][31:0]      lo_i,
  input  logic [1:0][31:0]      quo_i,
  output sgpg_pkg::pipe_ctl_t   ctl_o,
  output logic [1:0][B_W-1:0]   rem_o,
  output logic [1:0][31:0]      lo_o,
  output logic [1:0][31:0]      quo_o
);
  import sgpg_pkg::*;

  pipe_ctl_t           ctl_r;
  logic [1:0][B_W-1:0] rem_r, rem_nxt;
  logic [1:0][31:0]    lo_r, lo_nxt;
  logic [1:0][31:0]    quo_r, quo_nxt;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      logic [B_W:0] trial;
      logic         ge;
      trial      = {rem_i[a], lo_i[a][31]};
      ge         = trial >= {1'b0, divisor};
      rem_nxt[a] = ge ? B_W'(trial - {1'b0, divisor}) : B_W'(trial);
      lo_nxt[a]  = {lo_i[a][30:0], 1'b0};
      quo_nxt[a] = {quo_i[a][30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign lo_o  = lo_r;
  assign quo_o = quo_r;

endmodule

[rtl/sgpg_series_cell.sv]
// ----------------------------------------------------------------------------
// sgpg_series_cell
// One Taylor term of sine and cosine for both angles, over two stages:
// power update, then division by the term constant and accumulation.
// ----------------------------------------------------------------------------
module sgpg_series_cell #(
  parameter int K = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sgpg_pkg::pipe_ctl_t   ctl_i,
  input  sgpg_pkg::angle_pair_t ang_i,
  output sgpg_pkg::pipe_ctl_t   ctl_o,
  output sgpg_pkg::angle_pair_t ang_o
);
  import sgpg_pkg::*;

  localparam int          SK    = (K <= SIN_TERMS) ? K : SIN_TERMS;
  localparam logic [30:0] S_RCP = SIN_RCP[SK];
  localparam int          S_SH  = SIN_SH[SK];
  localparam logic [30:0] C_RCP = COS_RCP[K];
  localparam int          C_SH  = COS_SH[K];
  localparam bit          SUB   = (K % 2) == 1;

  pipe_ctl_t   mid_ctl_r, out_ctl_r;
  angle_pair_t mid_ang_r, mid_ang_nxt, out_ang_r, out_ang_nxt;

  always_comb begin
    mid_ang_nxt = ang_i;
    for (int a = 0; a < 2; a++) begin
      logic [59:0] ps;
      logic [60:0] pc;
      ps = 60'(ang_i[a].term_s) * 60'(ang_i[a].x2);
      pc = 61'(ang_i[a].term_c) * 61'(ang_i[a].x2);
      mid_ang_nxt[a].p_s = 30'(ps >> 30);
      mid_ang_nxt[a].p_c = 30'(pc >> 30);
    end
  end

  always_comb begin
    out_ang_nxt = mid_ang_r;
    for (int a = 0; a < 2; a++) begin
      logic [60:0] qs;
      logic [60:0] qc;
      logic [29:0] ts;
      logic [29:0] tc;
      qs = 61'(mid_ang_r[a].p_s) * 61'(S_RCP);
      qc = 61'(mid_ang_r[a].p_c) * 61'(C_RCP);
      ts = 30'(qs >> S_SH);
      tc = 30'(qc >> C_SH);
      if (K <= SIN_TERMS) begin
        out_ang_nxt[a].term_s = ts;
        out_ang_nxt[a].sum_s  = SUB ? mid_ang_r[a].sum_s - $signed({3'b000, ts})
                                    : mid_ang_r[a].sum_s + $signed({3'b000, ts});
      end
      out_ang_nxt[a].term_c = {1'b0, tc};
      out_ang_nxt[a].sum_c  = SUB ? mid_ang_r[a].sum_c - $signed({3'b000, tc})
                                  : mid_ang_r[a].sum_c + $signed({3'b000, tc});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_ctl_r <= '0;
      out_ctl_r <= '0;
    end else if (en) begin
      mid_ctl_r <= ctl_i;
      out_ctl_r <= mid_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_ang_r <= mid_ang_nxt;
      out_ang_r <= out_ang_nxt;
    end
  end

  assign ctl_o = out_ctl_r;
  assign ang_o = out_ang_r;

endmodule

[rtl/spherical_grid_point_generator.sv]
// ----------------------------------------------------------------------------
// spherical_grid_point_generator
// Maps equiangular sphere grid indexes to Cartesian points in signed Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a ring index i and a column index j per transaction; out_ch
//   returns radius * (sin(theta)cos(phi), sin(theta)sin(phi), cos(theta)) with
//   theta = pi*(2i+1)/(4B) and phi = pi*j/B, plus an out-of-range flag that
//   is set, with zero coordinates, when i or j is at least 2B.
//   cfg_ch writes the bandwidth B (index 0) and the Q8.8 radius (index 1);
//   writes to other indexes are dropped. Write only while no item is in
//   flight.
//   Throughput is one transaction per cycle while out_ch is not stalled. From the
//   input transaction to a valid result, an item passes 32 division cells (one
//   quotient bit each), angle reduction, squaring, six two-stage series cells,
//   sign recovery, the first product and the output register.
//   When the receiver stalls, the whole pipeline holds and in_ch.ready drops
//   in the same cycle; bubbles ahead of the output stay where they are.
//   Synchronous reset clears all valid bits and loads B = 32, radius = 25.0.
// ----------------------------------------------------------------------------
module spherical_grid_point_generator #(
  parameter int MAX_BANDWIDTH = sgpg_pkg::MAX_BANDWIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  sgpg_cfg_if.sink      cfg_ch,
  sgpg_in_if.sink       in_ch,
  sgpg_out_if.source    out_ch
);
  import sgpg_pkg::*;

  localparam int B_W     = $clog2(MAX_BANDWIDTH + 1);
  localparam int N_DIV   = 32;

  // Configuration registers.
  logic [7:0]  bandwidth_r;
  logic [15:0] radius_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bandwidth_r <= BANDWIDTH_RESET;
      radius_r    <= RADIUS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IDX_BANDWIDTH: bandwidth_r <= cfg_ch.data[7:0];
        CFG_IDX_RADIUS:    radius_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The bandwidth saturates at the largest grid the block is built for.
  logic [B_W-1:0] b_eff;
  assign b_eff = (32'(bandwidth_r) > 32'(MAX_BANDWIDTH)) ? B_W'(MAX_BANDWIDTH)
                                                         : B_W'(bandwidth_r);

  // The entire pipeline advances together unless the output is stalled.
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Division chain. The polar angle is (2i+1)*2^29/B and the azimuth
  // j*2^31/B; for in-range indexes both quotients fit in 32 bits, so the
  // dividend bits above bit 31 load straight into the partial remainder.
  pipe_ctl_t           div_ctl [N_DIV+1];
  logic [1:0][B_W-1:0] div_rem [N_DIV+1];
  logic [1:0][31:0]    div_lo  [N_DIV+1];
  logic [1:0][31:0]    div_quo [N_DIV+1];

  assign div_ctl[0].valid = in_ch.valid && en;
  assign div_ctl[0].oor   = (32'(in_ch.ring_index) >= 32'({b_eff, 1'b0})) ||
                            (32'(in_ch.column_index) >= 32'({b_eff, 1'b0}));
  assign div_rem[0][0]    = B_W'(in_ch.ring_index[7:2]);
  assign div_lo[0][0]     = {in_ch.ring_index[1:0], 1'b1, 29'd0};
  assign div_rem[0][1]    = B_W'(in_ch.column_index[7:1]);
  assign div_lo[0][1]     = {in_ch.column_index[0], 31'd0};
  assign div_quo[0]       = '0;

  for (genvar c = 0; c < N_DIV; c++) begin : g_div
    sgpg_div_cell #(.B_W(B_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .divisor (b_eff),
      .ctl_i   (div_ctl[c]),
      .rem_i   (div_rem[c]),
      .lo_i    (div_lo[c]),
      .quo_i   (div_quo[c]),
      .ctl_o   (div_ctl[c+1]),
      .rem_o   (div_rem[c+1]),
      .lo_o    (div_lo[c+1]),
      .quo_o   (div_quo[c+1])
    );
  end

  // Angle reduction: quadrant, mirror of the upper half quadrant, and
  // conversion of the turn fraction to radians in Q2.30.
  pipe_ctl_t   red_ctl_r;
  angle_pair_t red_ang_r, red_ang_nxt;

  always_comb begin
    red_ang_nxt = '0;
    for (int a = 0; a < 2; a++) begin
      logic [29:0] f;
      logic [29:0] g;
      logic [61:0] prod;
      f    = div_quo[N_DIV][a][29:0];
      g    = f[29] ? 30'(ONE_Q30 - {1'b0, f}) : f;
      prod = 62'(g) * 62'(PI_Q30);
      red_ang_nxt[a].quad   = div_quo[N_DIV][a][31:30];
      red_ang_nxt[a].swap   = f[29];
      red_ang_nxt[a].term_s = 30'(prod >> 31);
    end
  end

  // Squaring stage seeds both series: sine starts at x, cosine at one.
  pipe_ctl_t   ser_ctl [COS_TERMS+1];
  angle_pair_t ser_ang [COS_TERMS+1];
  pipe_ctl_t   sq_ctl_r;
  angle_pair_t sq_ang_r, sq_ang_nxt;

  always_comb begin
    sq_ang_nxt = red_ang_r;
    for (int a = 0; a < 2; a++) begin
      logic [59:0] sq;
      sq = 60'(red_ang_r[a].term_s) * 60'(red_ang_r[a].term_s);
      sq_ang_nxt[a].x2     = 30'(sq >> 30);
      sq_ang_nxt[a].sum_s  = $signed({3'b000, red_ang_r[a].term_s});
      sq_ang_nxt[a].term_c = ONE_Q30;
      sq_ang_nxt[a].sum_c  = $signed({2'b00, ONE_Q30});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_ctl_r <= '0;
      sq_ctl_r  <= '0;
    end else if (en) begin
      red_ctl_r <= div_ctl[N_DIV];
      sq_ctl_r  <= red_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_ang_r <= red_ang_nxt;
      sq_ang_r  <= sq_ang_nxt;
    end
  end

  assign ser_ctl[0] = sq_ctl_r;
  assign ser_ang[0] = sq_ang_r;

  for (genvar k = 1; k <= COS_TERMS; k++) begin : g_ser
    sgpg_series_cell #(.K(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ser_ctl[k-1]),
      .ang_i (ser_ang[k-1]),
      .ctl_o (ser_ctl[k]),
      .ang_o (ser_ang[k])
    );
  end

  // Sign recovery: clamp the series, undo the mirror, apply the quadrant.
  // Index 0 holds the polar angle, index 1 the azimuth.
  pipe_ctl_t        sc_ctl_r;
  logic [1:0][30:0] sin_m_r, sin_m_nxt, cos_m_r, cos_m_nxt;
  logic [1:0]       sin_n_r, sin_n_nxt, cos_n_r, cos_n_nxt;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      logic [30:0] s0;
      logic [30:0] c0;
      logic [30:0] s;
      logic [30:0] c;
      s0 = ser_ang[COS_TERMS][a].sum_s[32] ? 31'd0 : 31'(ser_ang[COS_TERMS][a].sum_s);
      c0 = ser_ang[COS_TERMS][a].sum_c[32] ? 31'd0 : 31'(ser_ang[COS_TERMS][a].sum_c);
      s  = ser_ang[COS_TERMS][a].swap ? c0 : s0;
      c  = ser_ang[COS_TERMS][a].swap ? s0 : c0;
      unique case (ser_ang[COS_TERMS][a].quad)
        2'd0: begin
          sin_m_nxt[a] = s; sin_n_nxt[a] = 1'b0;
          cos_m_nxt[a] = c; cos_n_nxt[a] = 1'b0;
        end
        2'd1: begin
          sin_m_nxt[a] = c; sin_n_nxt[a] = 1'b0;
          cos_m_nxt[a] = s; cos_n_nxt[a] = 1'b1;
        end
        2'd2: begin
          sin_m_nxt[a] = s; sin_n_nxt[a] = 1'b1;
          cos_m_nxt[a] = c; cos_n_nxt[a] = 1'b1;
        end
        default: begin
          sin_m_nxt[a] = c; sin_n_nxt[a] = 1'b1;
          cos_m_nxt[a] = s; cos_n_nxt[a] = 1'b0;
        end
      endcase
    end
  end

  // First products: sin(theta)*cos(phi), sin(theta)*sin(phi), and z directly.
  pipe_ctl_t   m1_ctl_r;
  logic [30:0] mx_r, my_r;
  logic [15:0] zm_r;
  logic        nx_r, ny_r, nz_r;
  logic [61:0] mx_prod, my_prod;
  logic [46:0] zm_prod;

  assign mx_prod = 62'(sin_m_r[0]) * 62'(cos_m_r[1]);
  assign my_prod = 62'(sin_m_r[0]) * 62'(sin_m_r[1]);
  assign zm_prod = 47'(cos_m_r[0]) * 47'(radius_r) + HALF_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_ctl_r <= '0;
      m1_ctl_r <= '0;
    end else if (en) begin
      sc_ctl_r <= ser_ctl[COS_TERMS];
      m1_ctl_r <= sc_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_m_r <= sin_m_nxt;
      sin_n_r <= sin_n_nxt;
      cos_m_r <= cos_m_nxt;
      cos_n_r <= cos_n_nxt;
      mx_r    <= 31'(mx_prod >> 30);
      my_r    <= 31'(my_prod >> 30);
      zm_r    <= 16'(zm_prod >> 30);
      nx_r    <= sin_n_r[0] ^ cos_n_r[1];
      ny_r    <= sin_n_r[0] ^ sin_n_r[1];
      nz_r    <= cos_n_r[0];
    end
  end

  // Output stage: radius scaling with rounding, sign, out-of-range zeroing.
  logic [46:0]        vx_prod, vy_prod;
  logic [15:0]        vx, vy;
  logic signed [16:0] px_r, py_r, pz_r;
  logic               oor_r;

  assign vx_prod = 47'(mx_r) * 47'(radius_r) + HALF_Q30;
  assign vy_prod = 47'(my_r) * 47'(radius_r) + HALF_Q30;
  assign vx      = 16'(vx_prod >> 30);
  assign vy      = 16'(vy_prod >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m1_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r <= m1_ctl_r.oor;
      px_r  <= m1_ctl_r.oor ? 17'sd0 : (nx_r ? -$signed({1'b0, vx}) : $signed({1'b0, vx}));
      py_r  <= m1_ctl_r.oor ? 17'sd0 : (ny_r ? -$signed({1'b0, vy}) : $signed({1'b0, vy}));
      pz_r  <= m1_ctl_r.oor ? 17'sd0 : (nz_r ? -$signed({1'b0, zm_r}) : $signed({1'b0, zm_r}));
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.point_x            = px_r;
  assign out_ch.point_y            = py_r;
  assign out_ch.point_z            = pz_r;
  assign out_ch.index_out_of_range = oor_r;

  // An out-of-range result carries zero coordinates.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.index_out_of_range |->
      out_ch.point_x == 17'sd0 && out_ch.point_y == 17'sd0 && out_ch.point_z == 17'sd0)
    else $error("out-of-range result with nonzero coordinates");

  // The z coordinate never exceeds the radius in magnitude.
  a_z_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.index_out_of_range |->
      $signed({out_ch.point_z[16], out_ch.point_z}) <= $signed({2'b00, radius_r}) &&
      $signed({out_ch.point_z[16], out_ch.point_z}) >= -$signed({2'b00, radius_r}))
    else $error("z coordinate outside the sphere radius");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A stalled output freezes the stage feeding it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(m1_ctl_r) && $stable(mx_r) && $stable(zm_r))
    else $error("pipeline moved while the output was stalled");

endmodule
